// ===== rtl/core/two_level_name_interning_table_assert.svh =====
// Assertion macros for the two-level name interning table.
`ifndef TWO_LEVEL_NAME_INTERNING_TABLE_ASSERT_SVH
`define TWO_LEVEL_NAME_INTERNING_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define NIT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("name table assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define NIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("name table assertion failed");
`else
`define NIT_ASSERT_SAME(lbl, ante, cons)
`define NIT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/nit_pkg.sv =====
// Shared types and constants of the name interning table.
package nit_pkg;

  localparam int MODE_W = 3;
  localparam int ID_W   = 5;
  localparam int CHAR_W = 8;

  localparam logic [MODE_W-1:0] MODE_INTERN_SVC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INTERN_OP  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP_SVC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP_OP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SVC_NAME   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_OP_NAME    = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_take;     // latch the first item of a request
    logic chr_wr;      // store a name character
    logic buf_op;      // pending buffer select: operation name
    logic len_clr;
    logic svc_len_ld;
    logic kind_ld;
    logic kind_op;
    logic tlen_ld;
    logic tlen_svc;
    logic tlen_ram;
    logic slot_clr;
    logic slot_inc;
    logic slot_sid;
    logic slot_oid;
    logic pos_clr;
    logic pos_inc;
    logic svcs_slot;
    logic svcs_sid;
    logic opsn_ld;
    logic chr_we;
    logic len_we;
    logic cnt_inc;
    logic ops_we_inc;
    logic id_zero;
    logic id_slot;
    logic id_sid;
    logic id_oid;
    logic out_ld_res;
    logic out_ld_chr;
  } nit_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              in_chr_zero;
    logic [MODE_W-1:0] mode;
    logic              kind_op;
    logic              len_ok;
    logic              svc_len_ok;
    logic              sid_ok;
    logic              oid_ok;
    logic              slot_end;
    logic              len_eq;
    logic              chr_eq;
    logic              pos_last;
    logic              svc_full;
    logic              op_full;
    logic              out_free;
  } nit_sts_t;

endpackage

// ===== rtl/core/nit_in_if.sv =====
// Request channel interface of the name interning table.
interface nit_in_if import nit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] name_char;
  logic [ID_W-1:0]   svc_id;
  logic [ID_W-1:0]   op_id;

  modport source (output valid, mode, name_char, svc_id, op_id, input ready);
  modport sink (input valid, mode, name_char, svc_id, op_id, output ready);
endinterface

// ===== rtl/core/nit_out_if.sv =====
// Result channel interface of the name interning table.
interface nit_out_if import nit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   result_id;
  logic [CHAR_W-1:0] result_char;
  logic              found;
  logic              last;

  modport source (output valid, result_id, result_char, found, last, input ready);
  modport sink (input valid, result_id, result_char, found, last, output ready);
endinterface

// ===== rtl/core/nit_ram.sv =====
// Generic single-port-write RAM with registered read.
module nit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/nit_dp.sv =====
// Datapath of the name interning table: name stores, counters and result register.
module nit_dp import nit_pkg::*; #(
  parameter int NAME_LIMIT    = 32,
  parameter int SERVICE_SLOTS = 16,
  parameter int OP_SLOTS      = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [CHAR_W-1:0] in_name_char,
  input  logic [ID_W-1:0]   in_svc_id,
  input  logic [ID_W-1:0]   in_op_id,
  input  nit_cmd_t          cmd,
  output nit_sts_t          sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_result_id,
  output logic [CHAR_W-1:0] out_result_char,
  output logic              out_found,
  output logic              out_last
);
  localparam int PW   = $clog2(NAME_LIMIT);
  localparam int LW   = $clog2(NAME_LIMIT + 1);
  localparam int SIW  = (SERVICE_SLOTS > 1) ? $clog2(SERVICE_SLOTS) : 1;
  localparam int OIW  = (OP_SLOTS > 1) ? $clog2(OP_SLOTS) : 1;
  localparam int CW   = $clog2(SERVICE_SLOTS + 1);
  localparam int OCW  = $clog2(OP_SLOTS + 1);
  localparam int MAXS = (SERVICE_SLOTS > OP_SLOTS) ? SERVICE_SLOTS : OP_SLOTS;
  localparam int SCW  = $clog2(MAXS + 1);
  localparam int SMPW = (CW > ID_W) ? CW : ID_W;
  localparam int OMPW = (OCW > ID_W) ? OCW : ID_W;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ID_W-1:0]   sid_r, sid_nxt, oid_r, oid_nxt;
  logic [LW-1:0]     len_r, len_nxt, svc_len_r, svc_len_nxt, tlen_r, tlen_nxt, len_base;
  logic              kind_r, kind_nxt;
  logic [SCW-1:0]    slot_r, slot_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [SIW-1:0]    svc_slot_r, svc_slot_nxt;
  logic [OCW-1:0]    opsn_r, opsn_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              id_ok_r, id_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [CHAR_W-1:0] out_chr_r, out_chr_nxt;
  logic              out_found_r, out_found_nxt, out_last_r, out_last_nxt;

  logic              pend_we;
  logic [CHAR_W-1:0] pend_svc_rd, pend_op_rd, pend_rd;
  logic [CHAR_W-1:0] svc_chr_rd, op_chr_rd, chr_rd;
  logic [PW-1:0]     svc_len_rd, op_len_rd, len_rd;
  logic [OCW-1:0]    ops_rd, ops_wdata;
  logic [SIW-1:0]    ops_waddr;

  // Pending length saturates at the limit; only the first NAME_LIMIT-1 characters are stored.
  always_comb begin
    len_base = (cmd.in_take || cmd.len_clr) ? '0 : len_r;
    pend_we  = cmd.chr_wr && (len_base < LW'(NAME_LIMIT - 1));
    len_nxt  = len_base;
    if (cmd.chr_wr && (len_base < LW'(NAME_LIMIT))) begin
      len_nxt = len_base + LW'(1);
    end
  end

  always_comb begin
    mode_nxt     = cmd.in_take ? in_mode : mode_r;
    sid_nxt      = cmd.in_take ? in_svc_id : sid_r;
    oid_nxt      = cmd.in_take ? in_op_id : oid_r;
    svc_len_nxt  = svc_len_r;
    if (cmd.svc_len_ld) begin
      svc_len_nxt = cmd.in_take ? '0 : len_r;
    end
    kind_nxt     = cmd.kind_ld ? cmd.kind_op : kind_r;
    tlen_nxt     = tlen_r;
    if (cmd.tlen_ld) begin
      if (cmd.tlen_ram) begin
        tlen_nxt = LW'(len_rd);
      end else if (cmd.tlen_svc) begin
        tlen_nxt = svc_len_r;
      end else begin
        tlen_nxt = len_r;
      end
    end
    slot_nxt = slot_r;
    if (cmd.slot_clr) begin
      slot_nxt = '0;
    end else if (cmd.slot_inc) begin
      slot_nxt = slot_r + SCW'(1);
    end else if (cmd.slot_sid) begin
      slot_nxt = SCW'(sid_r - ID_W'(1));
    end else if (cmd.slot_oid) begin
      slot_nxt = SCW'(oid_r - ID_W'(1));
    end
    pos_nxt = pos_r;
    if (cmd.pos_clr) begin
      pos_nxt = '0;
    end else if (cmd.pos_inc) begin
      pos_nxt = pos_r + PW'(1);
    end
    svc_slot_nxt = svc_slot_r;
    if (cmd.svcs_slot) begin
      svc_slot_nxt = slot_r[SIW-1:0];
    end else if (cmd.svcs_sid) begin
      svc_slot_nxt = SIW'(sid_r - ID_W'(1));
    end
    opsn_nxt = cmd.opsn_ld ? ops_rd : opsn_r;
    cnt_nxt  = cmd.cnt_inc ? cnt_r + CW'(1) : cnt_r;
    id_nxt   = id_r;
    id_ok_nxt = id_ok_r;
    if (cmd.id_zero) begin
      id_nxt    = '0;
      id_ok_nxt = 1'b0;
    end else if (cmd.id_slot) begin
      id_nxt    = ID_W'(slot_r + SCW'(1));
      id_ok_nxt = 1'b1;
    end else if (cmd.id_sid) begin
      id_nxt    = sid_r;
      id_ok_nxt = 1'b1;
    end else if (cmd.id_oid) begin
      id_nxt    = oid_r;
      id_ok_nxt = 1'b1;
    end
  end

  // Result register: a result waits here while the controller moves on.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_chr_nxt   = out_chr_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    if (cmd.out_ld_res) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = id_r;
      out_chr_nxt   = '0;
      out_found_nxt = id_ok_r;
      out_last_nxt  = 1'b1;
    end else if (cmd.out_ld_chr) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = id_r;
      out_chr_nxt   = chr_rd;
      out_found_nxt = 1'b1;
      out_last_nxt  = sts.pos_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    sid_r       <= sid_nxt;
    oid_r       <= oid_nxt;
    len_r       <= len_nxt;
    svc_len_r   <= svc_len_nxt;
    tlen_r      <= tlen_nxt;
    kind_r      <= kind_nxt;
    slot_r      <= slot_nxt;
    pos_r       <= pos_nxt;
    svc_slot_r  <= svc_slot_nxt;
    opsn_r      <= opsn_nxt;
    id_r        <= id_nxt;
    id_ok_r     <= id_ok_nxt;
    out_id_r    <= out_id_nxt;
    out_chr_r   <= out_chr_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  nit_ram #(.WIDTH(CHAR_W), .DEPTH(1 << PW)) u_pend_svc (
    .clk(clk), .we(pend_we && !cmd.buf_op), .waddr(len_base[PW-1:0]),
    .wdata(in_name_char), .raddr(pos_r), .rdata(pend_svc_rd)
  );

  nit_ram #(.WIDTH(CHAR_W), .DEPTH(1 << PW)) u_pend_op (
    .clk(clk), .we(pend_we && cmd.buf_op), .waddr(len_base[PW-1:0]),
    .wdata(in_name_char), .raddr(pos_r), .rdata(pend_op_rd)
  );

  nit_ram #(.WIDTH(CHAR_W), .DEPTH(1 << (SIW + PW))) u_svc_chr (
    .clk(clk), .we(cmd.chr_we && !kind_r), .waddr({slot_r[SIW-1:0], pos_r}),
    .wdata(pend_svc_rd), .raddr({slot_r[SIW-1:0], pos_r}), .rdata(svc_chr_rd)
  );

  nit_ram #(.WIDTH(CHAR_W), .DEPTH(1 << (SIW + OIW + PW))) u_op_chr (
    .clk(clk), .we(cmd.chr_we && kind_r), .waddr({svc_slot_r, slot_r[OIW-1:0], pos_r}),
    .wdata(pend_op_rd), .raddr({svc_slot_r, slot_r[OIW-1:0], pos_r}), .rdata(op_chr_rd)
  );

  nit_ram #(.WIDTH(PW), .DEPTH(1 << SIW)) u_svc_len (
    .clk(clk), .we(cmd.len_we && !kind_r), .waddr(slot_r[SIW-1:0]),
    .wdata(tlen_r[PW-1:0]), .raddr(slot_r[SIW-1:0]), .rdata(svc_len_rd)
  );

  nit_ram #(.WIDTH(PW), .DEPTH(1 << (SIW + OIW))) u_op_len (
    .clk(clk), .we(cmd.len_we && kind_r), .waddr({svc_slot_r, slot_r[OIW-1:0]}),
    .wdata(tlen_r[PW-1:0]), .raddr({svc_slot_r, slot_r[OIW-1:0]}), .rdata(op_len_rd)
  );

  // A new service starts with no operations; an appended operation bumps its count.
  assign ops_waddr = kind_r ? svc_slot_r : slot_r[SIW-1:0];
  assign ops_wdata = cmd.cnt_inc ? '0 : opsn_r + OCW'(1);

  nit_ram #(.WIDTH(OCW), .DEPTH(1 << SIW)) u_ops_cnt (
    .clk(clk), .we(cmd.cnt_inc || cmd.ops_we_inc), .waddr(ops_waddr),
    .wdata(ops_wdata), .raddr(svc_slot_r), .rdata(ops_rd)
  );

  assign pend_rd = kind_r ? pend_op_rd : pend_svc_rd;
  assign chr_rd  = kind_r ? op_chr_rd : svc_chr_rd;
  assign len_rd  = kind_r ? op_len_rd : svc_len_rd;

  always_comb begin
    sts.in_mode     = in_mode;
    sts.in_chr_zero = (in_name_char == '0);
    sts.mode        = mode_r;
    sts.kind_op     = kind_r;
    sts.len_ok      = (len_r != '0) && (len_r < LW'(NAME_LIMIT));
    sts.svc_len_ok  = (svc_len_r != '0) && (svc_len_r < LW'(NAME_LIMIT));
    sts.sid_ok      = (sid_r != '0) && (SMPW'(sid_r) <= SMPW'(cnt_r));
    sts.oid_ok      = (oid_r != '0) && (OMPW'(oid_r) <= OMPW'(ops_rd));
    sts.slot_end    = (slot_r == (kind_r ? SCW'(opsn_r) : SCW'(cnt_r)));
    sts.len_eq      = (LW'(len_rd) == tlen_r);
    sts.chr_eq      = (chr_rd == pend_rd);
    sts.pos_last    = ((LW'(pos_r) + LW'(1)) == tlen_r);
    sts.svc_full    = (cnt_r >= CW'(SERVICE_SLOTS));
    sts.op_full     = (opsn_r >= OCW'(OP_SLOTS));
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_result_id   = out_id_r;
  assign out_result_char = out_chr_r;
  assign out_found       = out_found_r;
  assign out_last        = out_last_r;
endmodule

// ===== rtl/core/nit_ctrl.sv =====
// Controller state machine of the name interning table.
module nit_ctrl import nit_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  nit_sts_t sts,
  output nit_cmd_t cmd
);
  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_COLLECT  = 5'd1;
  localparam logic [4:0] ST_COLLECT2 = 5'd2;
  localparam logic [4:0] ST_FINAL    = 5'd3;
  localparam logic [4:0] ST_OPS_RD   = 5'd4;
  localparam logic [4:0] ST_OPS_LAT  = 5'd5;
  localparam logic [4:0] ST_S_LEN    = 5'd6;
  localparam logic [4:0] ST_S_LCHK   = 5'd7;
  localparam logic [4:0] ST_S_RD     = 5'd8;
  localparam logic [4:0] ST_S_CMP    = 5'd9;
  localparam logic [4:0] ST_CP_RD    = 5'd10;
  localparam logic [4:0] ST_CP_WR    = 5'd11;
  localparam logic [4:0] ST_APPEND   = 5'd12;
  localparam logic [4:0] ST_EMIT     = 5'd13;
  localparam logic [4:0] ST_RV_SVC   = 5'd14;
  localparam logic [4:0] ST_RV_OPS   = 5'd15;
  localparam logic [4:0] ST_RV_ORD   = 5'd16;
  localparam logic [4:0] ST_RV_OCHK  = 5'd17;
  localparam logic [4:0] ST_RV_LEN   = 5'd18;
  localparam logic [4:0] ST_RV_LLAT  = 5'd19;
  localparam logic [4:0] ST_RV_RD    = 5'd20;
  localparam logic [4:0] ST_RV_OUT   = 5'd21;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_take = 1'b1;
          case (sts.in_mode)
            MODE_SVC_NAME: state_nxt = ST_RV_SVC;
            MODE_OP_NAME:  state_nxt = ST_RV_OPS;
            MODE_INTERN_SVC, MODE_INTERN_OP, MODE_LOOKUP_SVC, MODE_LOOKUP_OP: begin
              if (!sts.in_chr_zero) begin
                cmd.chr_wr = 1'b1;
                cmd.buf_op = (sts.in_mode == MODE_LOOKUP_OP);
                state_nxt  = ST_COLLECT;
              end else if (sts.in_mode == MODE_INTERN_OP) begin
                cmd.svc_len_ld = 1'b1;
                state_nxt      = ST_COLLECT2;
              end else begin
                state_nxt = ST_FINAL;
              end
            end
            default: begin
              cmd.id_zero = 1'b1;
              state_nxt   = ST_EMIT;
            end
          endcase
        end
      end
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!sts.in_chr_zero) begin
            cmd.chr_wr = 1'b1;
            cmd.buf_op = (sts.mode == MODE_LOOKUP_OP);
          end else if (sts.mode == MODE_INTERN_OP) begin
            cmd.svc_len_ld = 1'b1;
            cmd.len_clr    = 1'b1;
            state_nxt      = ST_COLLECT2;
          end else begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_COLLECT2: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!sts.in_chr_zero) begin
            cmd.chr_wr = 1'b1;
            cmd.buf_op = 1'b1;
          end else begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        case (sts.mode)
          MODE_INTERN_OP: begin
            if (!sts.len_ok || !sts.svc_len_ok) begin
              cmd.id_zero = 1'b1;
              state_nxt   = ST_EMIT;
            end else begin
              cmd.kind_ld  = 1'b1;
              cmd.tlen_ld  = 1'b1;
              cmd.tlen_svc = 1'b1;
              cmd.slot_clr = 1'b1;
              state_nxt    = ST_S_LEN;
            end
          end
          MODE_LOOKUP_OP: begin
            if (!sts.len_ok || !sts.sid_ok) begin
              cmd.id_zero = 1'b1;
              state_nxt   = ST_EMIT;
            end else begin
              cmd.svcs_sid = 1'b1;
              state_nxt    = ST_OPS_RD;
            end
          end
          default: begin
            if (!sts.len_ok) begin
              cmd.id_zero = 1'b1;
              state_nxt   = ST_EMIT;
            end else begin
              cmd.kind_ld  = 1'b1;
              cmd.tlen_ld  = 1'b1;
              cmd.slot_clr = 1'b1;
              state_nxt    = ST_S_LEN;
            end
          end
        endcase
      end
      ST_OPS_RD: state_nxt = ST_OPS_LAT;
      ST_OPS_LAT: begin
        cmd.opsn_ld  = 1'b1;
        cmd.kind_ld  = 1'b1;
        cmd.kind_op  = 1'b1;
        cmd.tlen_ld  = 1'b1;
        cmd.slot_clr = 1'b1;
        state_nxt    = ST_S_LEN;
      end
      ST_S_LEN: begin
        if (!sts.slot_end) begin
          state_nxt = ST_S_LCHK;
        end else if (!sts.kind_op) begin
          if (sts.mode == MODE_LOOKUP_SVC || sts.svc_full) begin
            cmd.id_zero = 1'b1;
            state_nxt   = ST_EMIT;
          end else begin
            cmd.pos_clr = 1'b1;
            state_nxt   = ST_CP_RD;
          end
        end else if (sts.mode == MODE_LOOKUP_OP || sts.op_full) begin
          cmd.id_zero = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.pos_clr = 1'b1;
          state_nxt   = ST_CP_RD;
        end
      end
      ST_S_LCHK: begin
        if (sts.len_eq) begin
          cmd.pos_clr = 1'b1;
          state_nxt   = ST_S_RD;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = ST_S_LEN;
        end
      end
      ST_S_RD: state_nxt = ST_S_CMP;
      ST_S_CMP: begin
        if (!sts.chr_eq) begin
          cmd.slot_inc = 1'b1;
          state_nxt    = ST_S_LEN;
        end else if (sts.pos_last) begin
          if (!sts.kind_op && sts.mode == MODE_INTERN_OP) begin
            cmd.svcs_slot = 1'b1;
            state_nxt     = ST_OPS_RD;
          end else begin
            cmd.id_slot = 1'b1;
            state_nxt   = ST_EMIT;
          end
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = ST_S_RD;
        end
      end
      ST_CP_RD: state_nxt = ST_CP_WR;
      ST_CP_WR: begin
        cmd.chr_we = 1'b1;
        if (sts.pos_last) begin
          state_nxt = ST_APPEND;
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = ST_CP_RD;
        end
      end
      ST_APPEND: begin
        cmd.len_we = 1'b1;
        if (!sts.kind_op) begin
          cmd.cnt_inc = 1'b1;
          if (sts.mode == MODE_INTERN_OP) begin
            cmd.svcs_slot = 1'b1;
            state_nxt     = ST_OPS_RD;
          end else begin
            cmd.id_slot = 1'b1;
            state_nxt   = ST_EMIT;
          end
        end else begin
          cmd.ops_we_inc = 1'b1;
          cmd.id_slot    = 1'b1;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld_res = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_RV_SVC: begin
        if (!sts.sid_ok) begin
          cmd.id_zero = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.kind_ld  = 1'b1;
          cmd.slot_sid = 1'b1;
          cmd.id_sid   = 1'b1;
          state_nxt    = ST_RV_LEN;
        end
      end
      ST_RV_OPS: begin
        if (!sts.sid_ok) begin
          cmd.id_zero = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.svcs_sid = 1'b1;
          state_nxt    = ST_RV_ORD;
        end
      end
      ST_RV_ORD: state_nxt = ST_RV_OCHK;
      ST_RV_OCHK: begin
        if (!sts.oid_ok) begin
          cmd.id_zero = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.kind_ld  = 1'b1;
          cmd.kind_op  = 1'b1;
          cmd.slot_oid = 1'b1;
          cmd.id_oid   = 1'b1;
          state_nxt    = ST_RV_LEN;
        end
      end
      ST_RV_LEN: state_nxt = ST_RV_LLAT;
      ST_RV_LLAT: begin
        cmd.tlen_ld  = 1'b1;
        cmd.tlen_ram = 1'b1;
        cmd.pos_clr  = 1'b1;
        state_nxt    = ST_RV_RD;
      end
      ST_RV_RD: state_nxt = ST_RV_OUT;
      ST_RV_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld_chr = 1'b1;
          if (sts.pos_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.pos_inc = 1'b1;
            state_nxt   = ST_RV_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== rtl/core/two_level_name_interning_table.sv =====
// Two-level name interning table: services and, under each, operations get small ids.
// Name characters are taken one per cycle; the terminator starts a search of the
// stored names, and an intern request that finds no match appends a new name.
// Reverse lookups deliver one character at a time, waiting while a result is unread.
// Synchronous active-low reset empties both tables; name stores need no clearing pass.
`include "two_level_name_interning_table_assert.svh"
module two_level_name_interning_table import nit_pkg::*; #(
  parameter int NAME_LIMIT    = 32,
  parameter int SERVICE_SLOTS = 16,
  parameter int OP_SLOTS      = 16
) (
  input logic        clk,
  input logic        rst_n,
  nit_in_if.sink     in_req,
  nit_out_if.source  out_res
);
  // Commands and status join the controller to the datapath and nothing else.
  nit_cmd_t cmd;
  nit_sts_t sts;

  // The controller walks one request at a time: it collects the name into a
  // pending buffer, then scans the stored names slot by slot, comparing the
  // length first and then one character at a time from the name RAMs.
  nit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the name stores, the per-table counts and the result
  // register, so a finished result can wait while the next request arrives.
  nit_dp #(
    .NAME_LIMIT    (NAME_LIMIT),
    .SERVICE_SLOTS (SERVICE_SLOTS),
    .OP_SLOTS      (OP_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_req.mode),
    .in_name_char    (in_req.name_char),
    .in_svc_id       (in_req.svc_id),
    .in_op_id        (in_req.op_id),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_res.ready),
    .out_valid       (out_res.valid),
    .out_result_id   (out_res.result_id),
    .out_result_char (out_res.result_char),
    .out_found       (out_res.found),
    .out_last        (out_res.last)
  );

  // A result is only loaded into a free result register.
  `NIT_ASSERT_SAME(a_load_when_free, cmd.out_ld_res || cmd.out_ld_chr, sts.out_free)
  // A new service is never appended to a full table.
  `NIT_ASSERT_SAME(a_no_svc_overflow, cmd.cnt_inc, !sts.svc_full)
  // A new operation is never appended to a full service.
  `NIT_ASSERT_SAME(a_no_op_overflow, cmd.ops_we_inc, !sts.op_full)
  // Every loaded result shows up on the result channel in the next cycle.
  `NIT_ASSERT_NEXT(a_result_shown, cmd.out_ld_res || cmd.out_ld_chr, out_res.valid)
endmodule
